// ===== rtl/wbrp_pkg.sv =====
// Package for the write buffer ring pointer controller.
// Holds the command and status codes, pointer and result structs and field widths.
// No dependencies.
`default_nettype none

package wbrp_pkg;

  // Ring geometry
  localparam int MAX_SIZE_LOG2 = 16;
  localparam int MIN_SIZE_LOG2 = 7;
  localparam int PTR_W         = 16;
  localparam int LOG2_W        = 5;
  localparam int RCOUNT_W      = 17;

  // Stream payload widths
  localparam int IN_TDATA_W   = 16;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;
  localparam int OUT_FIELDS_W = 4 * PTR_W + RCOUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [LOG2_W-1:0] RING_SIZE_LOG2_RST = LOG2_W'(MIN_SIZE_LOG2);

  typedef enum logic [0:0] {
    REG_RING_SIZE_LOG2 = 1'b0
  } reg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE = 2'd0,
    CMD_SUBMIT  = 2'd1,
    CMD_SYNC    = 2'd2,
    CMD_DRAIN   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_OVER_FILL = 2'd2
  } status_e;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] subm;
    logic [PTR_W-1:0] syn;
    logic [PTR_W-1:0] ret;
  } ptr_t;

  typedef struct packed {
    status_e             status;
    logic [PTR_W-1:0]    pos;
    logic [PTR_W-1:0]    rstart;
    logic [RCOUNT_W-1:0] rcount;
    logic [PTR_W-1:0]    unsub;
    logic [PTR_W-1:0]    unsync;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/wbrp_regs.sv =====
// Configuration register bank of the ring pointer controller (APB-style port).
// Holds ring_size_log2 and derives the clamped ring index mask. Uses wbrp_pkg.
`default_nettype none

module wbrp_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wbrp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wbrp_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wbrp_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic      [wbrp_pkg::PTR_W-1:0]      mask_o
);
  import wbrp_pkg::*;

  logic [LOG2_W-1:0] size_log2_q;
  logic [LOG2_W-1:0] size_log2_d;
  logic [LOG2_W-1:0] size_lg;
  logic              addr_hit;
  logic              wr_en;

  assign pready   = 1'b1;
  assign addr_hit = (paddr[APB_ADDR_W-1] == REG_RING_SIZE_LOG2);
  assign wr_en    = psel && penable && pwrite && pready && addr_hit;

  // Take the low five data bits on a completed write request
  always_comb begin
    size_log2_d = size_log2_q;
    if (wr_en) begin
      size_log2_d = pwdata[LOG2_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= RING_SIZE_LOG2_RST;
    end else begin
      size_log2_q <= size_log2_d;
    end
  end

  // Read back the register at addresses with bit 2 clear; other addresses read as zero
  always_comb begin
    prdata = '0;
    if (addr_hit) begin
      prdata = {{(APB_DATA_W-LOG2_W){1'b0}}, size_log2_q};
    end
  end

  // Clamp the ring size into its legal range
  always_comb begin
    size_lg = size_log2_q;
    if (size_log2_q < LOG2_W'(MIN_SIZE_LOG2)) begin
      size_lg = LOG2_W'(MIN_SIZE_LOG2);
    end else if (size_log2_q > LOG2_W'(MAX_SIZE_LOG2)) begin
      size_lg = LOG2_W'(MAX_SIZE_LOG2);
    end
  end

  // One mask bit per index bit below the ring size
  always_comb begin
    for (int b = 0; b < PTR_W; b++) begin
      mask_o[b] = (LOG2_W'(b) < size_lg);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wbrp_step.sv =====
// Combinational command step of the ring pointer controller.
// Computes the next pointers and the result for one request. Uses wbrp_pkg.
`default_nettype none

module wbrp_step (
  input  wire wbrp_pkg::cmd_e             cmd_i,
  input  wire logic [wbrp_pkg::PTR_W-1:0] count_i,
  input  wire logic [wbrp_pkg::PTR_W-1:0] mask_i,
  input  wire wbrp_pkg::ptr_t             ptr_i,
  output wbrp_pkg::ptr_t                  ptr_o,
  output wbrp_pkg::result_t               res_o
);
  import wbrp_pkg::*;

  ptr_t             cur;
  logic [PTR_W-1:0] free_syn;
  logic [PTR_W-1:0] free_ret;
  logic [PTR_W-1:0] used_subm;
  logic [PTR_W-1:0] used_syn;
  logic [PTR_W-1:0] used_drain;
  logic [PTR_W-1:0] over_run;

  // Read the stored pointers modulo the current ring size
  always_comb begin
    cur.head = ptr_i.head & mask_i;
    cur.subm = ptr_i.subm & mask_i;
    cur.syn  = ptr_i.syn & mask_i;
    cur.ret  = ptr_i.ret & mask_i;
  end

  assign free_syn   = (cur.syn - cur.head - PTR_W'(1)) & mask_i;
  assign free_ret   = (cur.ret - cur.head - PTR_W'(1)) & mask_i;
  assign used_subm  = (cur.head - cur.subm) & mask_i;
  assign used_syn   = (cur.head - cur.syn) & mask_i;
  assign used_drain = (cur.syn - cur.ret) & mask_i;
  assign over_run   = count_i - free_ret;

  // Apply the command
  always_comb begin
    ptr_o        = cur;
    res_o.status = STAT_DONE;
    res_o.pos    = '0;
    res_o.rstart = '0;
    res_o.rcount = '0;
    case (cmd_i)
      CMD_RESERVE: begin
        res_o.pos = cur.head;
        if (free_syn < count_i) begin
          res_o.status = STAT_NO_SPACE;
        end else begin
          // Retire map entries the new data would overrun
          if (free_ret <= count_i) begin
            res_o.rcount = {1'b0, over_run};
            if (over_run != '0) begin
              res_o.rstart = cur.ret;
            end
            ptr_o.ret = (cur.ret + over_run) & mask_i;
          end
          ptr_o.head = (cur.head + count_i) & mask_i;
        end
      end
      CMD_SUBMIT: begin
        res_o.pos = cur.subm;
        if (count_i > used_subm) begin
          res_o.status = STAT_OVER_FILL;
        end else begin
          ptr_o.subm = (cur.subm + count_i) & mask_i;
        end
      end
      CMD_SYNC: begin
        res_o.pos = cur.syn;
        if (count_i > used_syn) begin
          res_o.status = STAT_OVER_FILL;
        end else begin
          ptr_o.syn = (cur.syn + count_i) & mask_i;
        end
      end
      default: begin
        // Drain: retire everything up to the sync pointer
        res_o.pos    = cur.syn;
        res_o.rcount = {1'b0, used_drain};
        if (used_drain != '0) begin
          res_o.rstart = cur.ret;
        end
        ptr_o.ret = cur.syn;
      end
    endcase
    res_o.unsub  = (ptr_o.head - ptr_o.subm) & mask_i;
    res_o.unsync = (ptr_o.head - ptr_o.syn) & mask_i;
  end

endmodule

`default_nettype wire

// ===== rtl/write_buffer_ring_pointers.sv =====
// Top level of the write buffer ring pointer controller.
// Instantiates wbrp_regs and wbrp_step; holds the request, pointer and result registers.
// Uses wbrp_pkg.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (reserve,
//   submit, sync advance, drain), tdata the entry count. Each request yields
//   exactly one result on the m_axis channel: tuser carries the status, tdata
//   the slot position, retired run and fill counts.
//   A request is taken into an input register, then the pointer logic moves
//   it to the result register when that register is free or being emptied.
//   The pointer update is combinational, so one request per cycle is
//   sustained while the receiver does not stall.
//   When the receiver stalls, the result register holds; the input register
//   takes one more request, then s_axis_tready drops until the result is taken.
//   Reset clears all four pointers to zero, empties both registers and sets
//   ring_size_log2 to 7. The APB port writes ring_size_log2 at address 0;
//   change it only while no request is in flight.
`default_nettype none

module write_buffer_ring_pointers (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] entry_count
  input  wire logic [wbrp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  wire logic [wbrp_pkg::CMD_W-1:0]       s_axis_tuser,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] slot_position, [31:16] retired_start, [48:32] retired_count,
  // [64:49] unsubmitted_count, [80:65] unsynced_count, [87:81] zero
  output logic      [wbrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic      [wbrp_pkg::STAT_W-1:0]      m_axis_tuser,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [wbrp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [wbrp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [wbrp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import wbrp_pkg::*;

  logic             in_valid_q;
  logic             in_valid_d;
  cmd_e             cmd_q;
  logic [PTR_W-1:0] count_q;
  logic             out_valid_q;
  logic             out_valid_d;
  result_t          res_q;
  result_t          step_res;
  ptr_t             ptr_q;
  ptr_t             ptr_d;
  ptr_t             step_ptr;
  logic [PTR_W-1:0] mask;
  logic             in_take;
  logic             move;

  wbrp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mask_o  (mask)
  );

  wbrp_step u_step (
    .cmd_i   (cmd_q),
    .count_i (count_q),
    .mask_i  (mask),
    .ptr_i   (ptr_q),
    .ptr_o   (step_ptr),
    .res_o   (step_res)
  );

  // Advance a request when the result register is free or being emptied
  assign move          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || move;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    ptr_d       = ptr_q;
    if (move) begin
      ptr_d = step_ptr;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (move) begin
      in_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      count_q <= s_axis_tdata;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                          res_q.unsync, res_q.unsub, res_q.rcount,
                          res_q.rstart, res_q.pos};

`ifndef SYNTHESIS
  // Stored pointers never carry bits beyond the ring size in use
  a_ptr_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (((ptr_q.head | ptr_q.subm | ptr_q.syn | ptr_q.ret) & ~$past(mask)) == '0))
    else $error("pointer stored outside ring mask");

  // A refused request leaves the pointers where they were
  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && step_res.status != STAT_DONE) |=>
      (ptr_q.head == $past(ptr_q.head & mask)) && (ptr_q.syn == $past(ptr_q.syn & mask)) &&
      (ptr_q.subm == $past(ptr_q.subm & mask)) && (ptr_q.ret == $past(ptr_q.ret & mask)))
    else $error("refused request moved a pointer");

  // A reserve without space retires nothing
  a_no_space_no_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == STAT_NO_SPACE) |-> (res_q.rcount == '0))
    else $error("retired entries on a refused reserve");

  // Backpressure only when both registers are full and the receiver stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("request side stalled without cause");
`endif

endmodule

`default_nettype wire
